### rtl/core/slex_pkg.sv
// Package for the source lexer: mode codes, token kinds, character codes,
// keyword table, payload structs and character classifier functions.
// No dependencies.
package slex_pkg;

    localparam int MAX_TEXT_CHARS = 8;
    localparam int LINE_BITS      = 16;

    localparam logic [3:0] M_IDLE       = 4'd0;
    localparam logic [3:0] M_SLASH      = 4'd1;
    localparam logic [3:0] M_LINE_CMT   = 4'd2;
    localparam logic [3:0] M_BLOCK_CMT  = 4'd3;
    localparam logic [3:0] M_BLOCK_STAR = 4'd4;
    localparam logic [3:0] M_IDENT      = 4'd5;
    localparam logic [3:0] M_NUMBER     = 4'd6;
    localparam logic [3:0] M_CHAR_OPEN  = 4'd7;
    localparam logic [3:0] M_CHAR_BODY  = 4'd8;
    localparam logic [3:0] M_ERROR      = 4'd9;

    localparam logic [4:0] K_RETURN   = 5'd0;
    localparam logic [4:0] K_VAR      = 5'd1;
    localparam logic [4:0] K_FUNC     = 5'd2;
    localparam logic [4:0] K_IDENT    = 5'd3;
    localparam logic [4:0] K_INT      = 5'd4;
    localparam logic [4:0] K_CHAR     = 5'd5;
    localparam logic [4:0] K_INTLIT   = 5'd6;
    localparam logic [4:0] K_CHARLIT  = 5'd7;
    localparam logic [4:0] K_IF       = 5'd8;
    localparam logic [4:0] K_ELIF     = 5'd9;
    localparam logic [4:0] K_ELSE     = 5'd10;
    localparam logic [4:0] K_SYM_BASE = 5'd11;
    localparam logic [4:0] K_SLASH    = 5'd21;
    localparam logic [4:0] K_ERROR    = 5'd22;

    localparam logic [1:0] E_NONE      = 2'd0;
    localparam logic [1:0] E_INVALID   = 2'd1;
    localparam logic [1:0] E_CHAR_BODY = 2'd2;
    localparam logic [1:0] E_NO_QUOTE  = 2'd3;

    localparam logic [7:0] C_SLASH   = 8'h2F;
    localparam logic [7:0] C_STAR    = 8'h2A;
    localparam logic [7:0] C_NEWLINE = 8'h0A;
    localparam logic [7:0] C_QUOTE   = 8'h27;
    localparam logic [7:0] C_UNDER   = 8'h5F;

    localparam int NUM_SYMS = 10;
    localparam logic [7:0] SYM_CHAR [NUM_SYMS] = '{
        8'h3D, 8'h3A, 8'h2C, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2B, 8'h2D, 8'h2A
    };

    localparam int NUM_KW = 8;
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'h0000_0000_0074_6E69,   // int
        64'h0000_0000_7261_6863,   // char
        64'h0000_0000_0072_6176,   // var
        64'h0000_0000_636E_7566,   // func
        64'h0000_6E72_7574_6572,   // return
        64'h0000_0000_0000_6669,   // if
        64'h0000_0000_6669_6C65,   // elif
        64'h0000_0000_6573_6C65    // else
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd3, 4'd4, 4'd3, 4'd4, 4'd6, 4'd2, 4'd4, 4'd4
    };
    localparam logic [4:0] KW_KIND [NUM_KW] = '{
        K_INT, K_CHAR, K_VAR, K_FUNC, K_RETURN, K_IF, K_ELIF, K_ELSE
    };

    typedef struct packed {
        logic [7:0] source_char;
        logic       source_end;
    } t_src;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] line_number;
        logic [63:0] token_text;
        logic [3:0]  text_length;
        logic        text_truncated;
        logic [1:0]  error_code;
        logic        run_last;
    } t_tok;

    function automatic logic f_is_alpha(logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic f_is_digit(logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic f_is_space(logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic [15:0] f_line(logic [LINE_BITS-1:0] v);
        logic [LINE_BITS+15:0] w;
        w = {16'd0, v};
        return w[15:0];
    endfunction

    function automatic t_tok f_tok(logic [4:0] kind, logic [63:0] text, logic [3:0] len,
                                   logic trunc, logic [1:0] err, logic [15:0] line);
        t_tok t;
        t.token_kind     = kind;
        t.line_number    = line;
        t.token_text     = text;
        t.text_length    = len;
        t.text_truncated = trunc;
        t.error_code     = err;
        t.run_last       = 1'b0;
        return t;
    endfunction

    function automatic t_tok f_finish(logic [3:0] mode, logic [63:0] text, logic [3:0] len,
                                      logic ovf, logic [15:0] line);
        logic       hit;
        logic [4:0] kw;
        hit = 1'b0;
        kw  = K_IDENT;
        if (mode != M_NUMBER && !ovf) begin
            for (int i = 0; i < NUM_KW; i++) begin
                if (!hit && len == KW_LEN[i] && text == KW_TEXT[i]) begin
                    hit = 1'b1;
                    kw  = KW_KIND[i];
                end
            end
        end
        if (hit) begin
            return f_tok(kw, 64'd0, 4'd0, 1'b0, E_NONE, line);
        end
        return f_tok((mode == M_NUMBER) ? K_INTLIT : K_IDENT, text, len, ovf, E_NONE, line);
    endfunction

endpackage

### rtl/core/source_lexer_top.sv
// An accepted byte passes the input register, then the result register, before its
// first token shows. Throughput: one byte per cycle while the token side takes each
// token and a byte yields at most one; a byte with two tokens holds the next input.
// Reset (synchronous, active low) empties both registers, sets the lexer idle with an
// empty text buffer and the line counter to one.
// Source lexer top level; depends on slex_pkg.
module source_lexer_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_src_valid,
    output logic            o_src_ready,
    input  slex_pkg::t_src  i_src,
    output logic            o_tok_valid,
    input  logic            i_tok_ready,
    output slex_pkg::t_tok  o_tok
);
    import slex_pkg::*;

    logic                 r_in_valid;
    t_src                 r_in;
    logic [3:0]           r_mode;
    logic [63:0]          r_buf;
    logic [3:0]           r_len;
    logic                 r_ovf;
    logic [LINE_BITS-1:0] r_line;
    t_tok                 r_res0;
    t_tok                 r_res1;
    logic [1:0]           r_rcnt;
    logic                 r_head;

    logic [3:0]           n_mode;
    logic [63:0]          n_buf;
    logic [3:0]           n_len;
    logic                 n_ovf;
    logic [LINE_BITS-1:0] n_line;
    logic [1:0]           n_rcnt;

    logic       tok_fire;
    logic       proc;
    logic [7:0] ch;
    logic [15:0] ln;
    logic       do_start;
    logic       a_v, b_v, c_v;
    t_tok       a_t, b_t, c_t;
    t_tok       s0, s1;
    logic       sym_hit;
    logic [4:0] sym_kind;

    assign tok_fire    = o_tok_valid && i_tok_ready;
    assign proc        = r_in_valid && (r_rcnt == 2'd0 || (r_rcnt == 2'd1 && tok_fire));
    assign o_src_ready = !r_in_valid || proc;
    assign o_tok_valid = (r_rcnt != 2'd0);
    assign o_tok       = r_head ? r_res1 : r_res0;
    assign ch          = r_in.source_char;
    assign ln          = f_line(r_line);

    always_comb begin
        sym_hit  = 1'b0;
        sym_kind = K_SYM_BASE;
        for (int i = 0; i < NUM_SYMS; i++) begin
            if (ch == SYM_CHAR[i]) begin
                sym_hit  = 1'b1;
                sym_kind = K_SYM_BASE + 5'(i);
            end
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_buf    = r_buf;
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_line   = r_line;
        do_start = 1'b0;
        a_v      = 1'b0;
        b_v      = 1'b0;
        c_v      = 1'b0;
        a_t      = f_tok(K_SLASH, 64'd0, 4'd0, 1'b0, E_NONE, ln);
        b_t      = a_t;
        c_t      = a_t;

        case (r_mode)
            M_ERROR: begin
            end
            M_SLASH: begin
                if (ch == C_SLASH) begin
                    n_mode = M_LINE_CMT;
                end else if (ch == C_STAR) begin
                    n_mode = M_BLOCK_CMT;
                end else begin
                    a_v      = 1'b1;
                    do_start = 1'b1;
                end
            end
            M_LINE_CMT: begin
                if (ch == C_NEWLINE) begin
                    if (r_line != '1) n_line = r_line + 1'b1;
                    n_mode = M_IDLE;
                end
            end
            M_BLOCK_CMT: begin
                if (ch == C_STAR) n_mode = M_BLOCK_STAR;
            end
            M_BLOCK_STAR: begin
                if (ch == C_SLASH) begin
                    n_mode = M_IDLE;
                end else if (ch != C_STAR) begin
                    n_mode = M_BLOCK_CMT;
                end
            end
            M_IDENT, M_NUMBER: begin
                if ((r_mode == M_IDENT && (f_is_alpha(ch) || f_is_digit(ch) || ch == C_UNDER))
                    || (r_mode == M_NUMBER && f_is_digit(ch))) begin
                    if (r_len < 4'(MAX_TEXT_CHARS)) begin
                        for (int b = 0; b < 8; b++) begin
                            if (4'(b) == r_len) n_buf[8*b +: 8] = ch;
                        end
                        n_len = r_len + 4'd1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else begin
                    a_v      = 1'b1;
                    a_t      = f_finish(r_mode, r_buf, r_len, r_ovf, ln);
                    n_buf    = 64'd0;
                    n_len    = 4'd0;
                    n_ovf    = 1'b0;
                    do_start = 1'b1;
                end
            end
            M_CHAR_OPEN: begin
                n_buf = 64'd0;
                n_len = 4'd0;
                n_ovf = 1'b0;
                if (f_is_alpha(ch) || f_is_digit(ch)) begin
                    n_buf[7:0] = ch;
                    n_len      = 4'd1;
                    n_mode     = M_CHAR_BODY;
                end else begin
                    a_v    = 1'b1;
                    a_t    = f_tok(K_ERROR, 64'd0, 4'd0, 1'b0, E_CHAR_BODY, ln);
                    n_mode = M_ERROR;
                end
            end
            M_CHAR_BODY: begin
                a_v   = 1'b1;
                n_buf = 64'd0;
                n_len = 4'd0;
                n_ovf = 1'b0;
                if (ch == C_QUOTE) begin
                    a_t    = f_tok(K_CHARLIT, r_buf, r_len, 1'b0, E_NONE, ln);
                    n_mode = M_IDLE;
                end else begin
                    a_t    = f_tok(K_ERROR, 64'd0, 4'd0, 1'b0, E_NO_QUOTE, ln);
                    n_mode = M_ERROR;
                end
            end
            default: begin
                do_start = 1'b1;
            end
        endcase

        if (do_start) begin
            n_mode = M_IDLE;
            if (ch == C_SLASH) begin
                n_mode = M_SLASH;
            end else if (f_is_alpha(ch) || f_is_digit(ch)) begin
                n_buf      = 64'd0;
                n_buf[7:0] = ch;
                n_len      = 4'd1;
                n_ovf      = 1'b0;
                n_mode     = f_is_alpha(ch) ? M_IDENT : M_NUMBER;
            end else if (sym_hit) begin
                b_v = 1'b1;
                b_t = f_tok(sym_kind, 64'd0, 4'd0, 1'b0, E_NONE, ln);
            end else if (ch == C_QUOTE) begin
                n_mode = M_CHAR_OPEN;
            end else if (ch == C_NEWLINE) begin
                if (r_line != '1) n_line = r_line + 1'b1;
            end else if (!f_is_space(ch)) begin
                b_v    = 1'b1;
                b_t    = f_tok(K_ERROR, {56'd0, ch}, 4'd1, 1'b0, E_INVALID, ln);
                n_buf  = 64'd0;
                n_len  = 4'd0;
                n_ovf  = 1'b0;
                n_mode = M_ERROR;
            end
        end

        if (r_in.source_end) begin
            case (n_mode)
                M_IDENT, M_NUMBER: begin
                    c_v = 1'b1;
                    c_t = f_finish(n_mode, n_buf, n_len, n_ovf, ln);
                end
                M_SLASH: begin
                    c_v = 1'b1;
                end
                M_CHAR_OPEN: begin
                    c_v = 1'b1;
                    c_t = f_tok(K_ERROR, 64'd0, 4'd0, 1'b0, E_CHAR_BODY, ln);
                end
                M_CHAR_BODY: begin
                    c_v = 1'b1;
                    c_t = f_tok(K_ERROR, 64'd0, 4'd0, 1'b0, E_NO_QUOTE, ln);
                end
                default: begin
                end
            endcase
            n_mode = M_IDLE;
            n_buf  = 64'd0;
            n_len  = 4'd0;
            n_ovf  = 1'b0;
            n_line = LINE_BITS'(1);
        end
    end

    always_comb begin
        s0 = a_v ? a_t : (b_v ? b_t : c_t);
        s1 = a_v ? (b_v ? b_t : c_t) : c_t;
        if (32'(a_v) + 32'(b_v) + 32'(c_v) >= 2) begin
            n_rcnt      = 2'd2;
            s1.run_last = 1'b1;
        end else if (a_v || b_v || c_v) begin
            n_rcnt      = 2'd1;
            s0.run_last = 1'b1;
        end else begin
            n_rcnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_IDLE;
            r_buf      <= 64'd0;
            r_len      <= 4'd0;
            r_ovf      <= 1'b0;
            r_line     <= LINE_BITS'(1);
            r_rcnt     <= 2'd0;
            r_head     <= 1'b0;
        end else begin
            if (i_src_valid && o_src_ready) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_mode <= n_mode;
                r_buf  <= n_buf;
                r_len  <= n_len;
                r_ovf  <= n_ovf;
                r_line <= n_line;
                r_rcnt <= n_rcnt;
                r_head <= 1'b0;
            end else if (tok_fire) begin
                if (r_rcnt == 2'd2) begin
                    r_rcnt <= 2'd1;
                    r_head <= 1'b1;
                end else begin
                    r_rcnt <= 2'd0;
                    r_head <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_src_valid && o_src_ready) r_in <= i_src;
        if (proc) begin
            r_res0 <= s0;
            r_res1 <= s1;
        end
    end

`ifndef ASSERT_OFF
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in.source_end |=> r_mode == M_IDLE && r_line == LINE_BITS'(1))
        else $error("end of source did not reset the lexer");
    a_error_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_mode == M_ERROR |-> n_rcnt == 2'd0)
        else $error("token produced while discarding after an error");
    a_head_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head |-> r_rcnt == 2'd1)
        else $error("second result slot selected with wrong count");
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == M_IDLE |-> r_len == 4'd0 && !r_ovf)
        else $error("text buffer not empty in idle mode");
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0)
        else $error("line counter reached zero");
`endif

endmodule

### tb/sv/source_lexer_tb_pkg.sv
// Token scoreboard for the source lexer testbench: a byte-level lexer
// predictor and the queue of tokens it expects. Depends on slex_pkg.
`timescale 1ns / 1ps
package source_lexer_tb_pkg;
    import slex_pkg::*;

    class token_scoreboard;
        logic [3:0]  mode;
        logic [63:0] word_text;
        logic [3:0]  word_len;
        logic        word_ovf;
        logic [15:0] line;
        t_tok        expected_tokens[$];
        t_tok        byte_tokens[$];
        int          failures;

        function new();
            failures = 0;
            restart();
        endfunction

        function void restart();
            mode = M_IDLE;
            clear_word();
            line = 16'd1;
        endfunction

        function void clear_word();
            word_text = '0;
            word_len  = '0;
            word_ovf  = 1'b0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_num(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function logic [63:0] pack_le(string s);
            logic [63:0] v;
            v = '0;
            for (int i = 0; i < s.len(); i++) v[8*i +: 8] = s[i];
            return v;
        endfunction

        function logic [4:0] keyword_kind(logic [63:0] text, logic [4:0] dflt);
            case (text)
                pack_le("int"):    return K_INT;
                pack_le("char"):   return K_CHAR;
                pack_le("var"):    return K_VAR;
                pack_le("func"):   return K_FUNC;
                pack_le("return"): return K_RETURN;
                pack_le("if"):     return K_IF;
                pack_le("elif"):   return K_ELIF;
                pack_le("else"):   return K_ELSE;
                default:           return dflt;
            endcase
        endfunction

        function bit symbol_kind(logic [7:0] c, output logic [4:0] kind);
            kind = K_SYM_BASE;
            case (c)
                "=": kind = K_SYM_BASE;
                ":": kind = K_SYM_BASE + 5'd1;
                ",": kind = K_SYM_BASE + 5'd2;
                "(": kind = K_SYM_BASE + 5'd3;
                ")": kind = K_SYM_BASE + 5'd4;
                "{": kind = K_SYM_BASE + 5'd5;
                "}": kind = K_SYM_BASE + 5'd6;
                "+": kind = K_SYM_BASE + 5'd7;
                "-": kind = K_SYM_BASE + 5'd8;
                "*": kind = K_SYM_BASE + 5'd9;
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void add_token(logic [4:0] kind, logic [63:0] text, logic [3:0] len,
                                logic trunc, logic [1:0] err);
            t_tok t;
            t.token_kind     = kind;
            t.line_number    = line;
            t.token_text     = text;
            t.text_length    = len;
            t.text_truncated = trunc;
            t.error_code     = err;
            t.run_last       = 1'b0;
            if (byte_tokens.size() < 2) byte_tokens = {byte_tokens, t};
        endfunction

        function void take_char(logic [7:0] c);
            if (word_len < MAX_TEXT_CHARS) begin
                word_text[8*word_len +: 8] = c;
                word_len++;
            end else begin
                word_ovf = 1'b1;
            end
        endfunction

        function void fail_with(logic [1:0] code, logic [63:0] text, logic [3:0] len);
            add_token(K_ERROR, text, len, 1'b0, code);
            clear_word();
            mode = M_ERROR;
        endfunction

        function void bump_line();
            if (line != 16'hFFFF) line++;
        endfunction

        function void close_word();
            logic [4:0] kind;
            kind = (mode == M_NUMBER) ? K_INTLIT : K_IDENT;
            if (kind == K_IDENT && !word_ovf) kind = keyword_kind(word_text, kind);
            if (kind == K_IDENT || kind == K_INTLIT)
                add_token(kind, word_text, word_len, word_ovf, E_NONE);
            else
                add_token(kind, '0, '0, 1'b0, E_NONE);
            clear_word();
            mode = M_IDLE;
        endfunction

        function void begin_token(logic [7:0] c);
            logic [4:0] kind;
            mode = M_IDLE;
            if (c == C_SLASH) begin
                mode = M_SLASH;
            end else if (is_letter(c)) begin
                clear_word();
                take_char(c);
                mode = M_IDENT;
            end else if (is_num(c)) begin
                clear_word();
                take_char(c);
                mode = M_NUMBER;
            end else if (symbol_kind(c, kind)) begin
                add_token(kind, '0, '0, 1'b0, E_NONE);
            end else if (c == C_QUOTE) begin
                mode = M_CHAR_OPEN;
            end else if (c == C_NEWLINE) begin
                bump_line();
            end else if (!is_blank(c)) begin
                fail_with(E_INVALID, {56'd0, c}, 4'd1);
            end
        endfunction

        // Returns 0 when the byte is dropped after an error.
        function bit note_byte(t_src s);
            logic [7:0] c;
            bit         live;
            c = s.source_char;
            live = (mode != M_ERROR);
            byte_tokens.delete();
            case (mode)
                M_ERROR: ;
                M_SLASH: begin
                    if (c == C_SLASH) mode = M_LINE_CMT;
                    else if (c == C_STAR) mode = M_BLOCK_CMT;
                    else begin
                        add_token(K_SLASH, '0, '0, 1'b0, E_NONE);
                        begin_token(c);
                    end
                end
                M_LINE_CMT: begin
                    if (c == C_NEWLINE) begin
                        bump_line();
                        mode = M_IDLE;
                    end
                end
                M_BLOCK_CMT: begin
                    if (c == C_STAR) mode = M_BLOCK_STAR;
                end
                M_BLOCK_STAR: begin
                    if (c == C_SLASH) mode = M_IDLE;
                    else if (c != C_STAR) mode = M_BLOCK_CMT;
                end
                M_IDENT: begin
                    if (is_letter(c) || is_num(c) || c == C_UNDER) take_char(c);
                    else begin
                        close_word();
                        begin_token(c);
                    end
                end
                M_NUMBER: begin
                    if (is_num(c)) take_char(c);
                    else begin
                        close_word();
                        begin_token(c);
                    end
                end
                M_CHAR_OPEN: begin
                    if (is_letter(c) || is_num(c)) begin
                        clear_word();
                        take_char(c);
                        mode = M_CHAR_BODY;
                    end else begin
                        fail_with(E_CHAR_BODY, '0, '0);
                    end
                end
                M_CHAR_BODY: begin
                    if (c == C_QUOTE) begin
                        add_token(K_CHARLIT, word_text, word_len, 1'b0, E_NONE);
                        clear_word();
                        mode = M_IDLE;
                    end else begin
                        fail_with(E_NO_QUOTE, '0, '0);
                    end
                end
                default: begin_token(c);
            endcase
            if (s.source_end) begin
                case (mode)
                    M_IDENT, M_NUMBER: close_word();
                    M_SLASH:           add_token(K_SLASH, '0, '0, 1'b0, E_NONE);
                    M_CHAR_OPEN:       fail_with(E_CHAR_BODY, '0, '0);
                    M_CHAR_BODY:       fail_with(E_NO_QUOTE, '0, '0);
                    default: ;
                endcase
                restart();
            end
            foreach (byte_tokens[i]) begin
                if (i == byte_tokens.size() - 1) byte_tokens[i].run_last = 1'b1;
                expected_tokens = {expected_tokens, byte_tokens[i]};
            end
            return live;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function void report(string field, logic [63:0] want, logic [63:0] got);
            $display("%0t mismatch %s: expected %h, actual %h", $time, field, want, got);
            failures++;
        endfunction

        function void check_token(t_tok got);
            t_tok want;
            if (expected_tokens.size() == 0) begin
                $display("%0t unexpected token: expected none, actual %h", $time, got);
                failures++;
                return;
            end
            want = expected_tokens.pop_front();
            if (got.token_kind !== want.token_kind)
                report("token_kind", want.token_kind, got.token_kind);
            if (got.line_number !== want.line_number)
                report("line_number", want.line_number, got.line_number);
            if (got.token_text !== want.token_text)
                report("token_text", want.token_text, got.token_text);
            if (got.text_length !== want.text_length)
                report("text_length", want.text_length, got.text_length);
            if (got.text_truncated !== want.text_truncated)
                report("text_truncated", want.text_truncated, got.text_truncated);
            if (got.error_code !== want.error_code)
                report("error_code", want.error_code, got.error_code);
            if (got.run_last !== want.run_last)
                report("run_last", want.run_last, got.run_last);
        endfunction
    endclass

endpackage

### tb/sv/source_lexer_top_tb.sv
// Top-level testbench for source_lexer_top: drives directed and then random source
// text in bursts, stalls the token side, and checks tokens against token_scoreboard.
// Depends on slex_pkg and source_lexer_tb_pkg.
`timescale 1ns / 1ps
module source_lexer_top_tb;
    import slex_pkg::*;
    import source_lexer_tb_pkg::*;

    localparam int LIVE_TARGET = 1300;
    localparam int CYCLE_LIMIT = 500000;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_src_valid = 1'b0;
    logic o_src_ready;
    t_src i_src       = '0;
    logic o_tok_valid;
    logic i_tok_ready = 1'b0;
    t_tok o_tok;

    token_scoreboard scoreboard = new();
    logic [7:0]      source_bytes[$];
    string           keyword_words[8] = '{"int", "char", "var", "func",
                                          "return", "if", "elif", "else"};
    string           symbol_chars = "=:,(){}+-*/";
    int              burst_left = 0;
    int              live_items = 0;
    int              cycle_count = 0;
    logic [7:0]      stall_cycle = '0;

    source_lexer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_src_valid (i_src_valid),
        .o_src_ready (o_src_ready),
        .i_src       (i_src),
        .o_tok_valid (o_tok_valid),
        .i_tok_ready (i_tok_ready),
        .o_tok       (o_tok)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL source_lexer_top");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        stall_cycle <= stall_cycle + 8'd1;
        case (stall_cycle[7:6])
            2'd0: i_tok_ready <= 1'b1;
            2'd1: i_tok_ready <= 1'($urandom_range(0, 1));
            2'd2: i_tok_ready <= (stall_cycle[2:0] != 3'd0);
            default: i_tok_ready <= stall_cycle[4];
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_tok_valid && i_tok_ready) scoreboard.check_token(o_tok);
    end

    task automatic send_byte(input logic [7:0] c, input logic last);
        t_src item;
        int   gap;
        item.source_char = c;
        item.source_end  = last;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_src_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_src       <= item;
        i_src_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_src_ready) @(posedge i_clk);
        if (scoreboard.note_byte(item)) live_items++;
    endtask

    task automatic send_source();
        for (int i = 0; i < source_bytes.size(); i++)
            send_byte(source_bytes[i], i == source_bytes.size() - 1);
        source_bytes.delete();
    endtask

    task automatic put_byte(input logic [7:0] c);
        source_bytes = {source_bytes, c};
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic drain();
        i_src_valid <= 1'b0;
        do @(posedge i_clk); while (scoreboard.pending() != 0);
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'(8'h61 + r) : 8'(8'h41 + r - 26);
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 52) return rand_letter();
        if (r < 62) return 8'(8'h30 + r - 52);
        return C_UNDER;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_blank();
        int r;
        r = $urandom_range(0, 6);
        return (r > 5) ? 8'h20 : 8'(8'h09 + r % 5);
    endfunction

    task automatic add_random_token();
        int         pick;
        int         n;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            add_text(keyword_words[$urandom_range(0, 7)]);
            if ($urandom_range(0, 5) == 0) put_byte(rand_word_char());
        end else if (pick < 35) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
            put_byte(rand_letter());
            repeat (n - 1) put_byte(rand_word_char());
        end else if (pick < 48) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
            repeat (n) put_byte(rand_digit());
        end else if (pick < 58) begin
            put_byte(C_QUOTE);
            put_byte(($urandom_range(0, 1) == 0) ? rand_letter() : rand_digit());
            put_byte(C_QUOTE);
        end else if (pick < 74) begin
            put_byte(symbol_chars[$urandom_range(0, 10)]);
        end else if (pick < 79) begin
            add_text("//");
            repeat ($urandom_range(0, 8)) begin
                c = 8'($urandom_range(0, 255));
                put_byte((c == C_NEWLINE) ? 8'h0B : c);
            end
            put_byte(C_NEWLINE);
        end else if (pick < 85) begin
            add_text("/*");
            repeat ($urandom_range(0, 10)) begin
                case ($urandom_range(0, 4))
                    0: put_byte(C_STAR);
                    1: put_byte(C_SLASH);
                    2: put_byte(C_NEWLINE);
                    3: put_byte(8'($urandom_range(0, 255)));
                    default: put_byte(rand_letter());
                endcase
            end
            add_text("*/");
        end else if (pick < 96) begin
            repeat ($urandom_range(1, 3)) put_byte(rand_blank());
        end else begin
            case ($urandom_range(0, 3))
                0: put_byte(8'($urandom_range(0, 255)));
                1: begin
                    put_byte(C_QUOTE);
                    put_byte(8'($urandom_range(0, 255)));
                end
                2: begin
                    put_byte(C_QUOTE);
                    put_byte(rand_letter());
                    put_byte(8'($urandom_range(0, 255)));
                end
                default: begin
                    put_byte(C_UNDER);
                    put_byte(rand_letter());
                end
            endcase
        end
    endtask

    task automatic build_source();
        int cut;
        repeat ($urandom_range(1, 25)) begin
            add_random_token();
            if ($urandom_range(0, 9) < 6) put_byte(rand_blank());
        end
        if ($urandom_range(0, 6) == 0 && source_bytes.size() > 3) begin
            cut = $urandom_range(1, 3);
            repeat (cut) void'(source_bytes.pop_back());
        end
    endtask

    initial begin
        bit paused;
        paused = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_text("abcdefghi 0/");
        send_source();
        add_text("=:,(){}+-*");
        send_source();
        add_text("x'");
        send_source();
        add_text("'7");
        send_source();
        add_text("'+");
        send_source();
        add_text("_");
        send_source();
        put_byte(8'hFF);
        send_source();
        drain();

        live_items = 0;
        while (live_items < LIVE_TARGET) begin
            build_source();
            send_source();
            if (!paused && live_items >= LIVE_TARGET / 2) begin
                paused = 1'b1;
                drain();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (scoreboard.failures == 0 && scoreboard.pending() == 0) begin
            $display("PASS source_lexer_top");
        end else begin
            $display("FAIL source_lexer_top");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/slex_pkg.sv
rtl/core/source_lexer_top.sv
tb/sv/source_lexer_tb_pkg.sv
tb/sv/source_lexer_top_tb.sv
